>>> hw/rtl/fssc_pkg.sv
`timescale 1ns / 1ps

package fssc_pkg;

	// Field widths fixed by the bus and the track memory interface.
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int PHASE_W = 7;
	localparam int TRACK_W = 6;
	localparam int NIB_W   = 13;

	localparam int TRACK_NIBBLES_DEF  = 6656;
	localparam int MAX_HEAD_PHASE_DEF = 70;

	// Soft switch codes on the low four address bits.
	localparam logic [3:0] SW_MAG_FIRST  = 4'h0;
	localparam logic [3:0] SW_MAG_LAST   = 4'h7;
	localparam logic [3:0] SW_DRV_OFF    = 4'h8;
	localparam logic [3:0] SW_DRV_ON     = 4'h9;
	localparam logic [3:0] SW_SEL_DRV0   = 4'hA;
	localparam logic [3:0] SW_SEL_DRV1   = 4'hB;
	localparam logic [3:0] SW_DATA       = 4'hC;
	localparam logic [3:0] SW_NOP        = 4'hD;
	localparam logic [3:0] SW_READ_MODE  = 4'hE;
	localparam logic [3:0] SW_WRITE_MODE = 4'hF;

	localparam logic [ADDR_W-1:0] PHASE_PROBE_ADDR = 16'h00E0;
	localparam logic [DATA_W-1:0] PROBE_DATA       = 8'hFF;

	typedef struct packed {
		logic [3:0]         magnet_on;
		logic [PHASE_W-1:0] head_phase;
		logic               selected_drive;
		logic [1:0]         drive_enabled;
		logic               write_selected;
		logic [NIB_W-1:0]   nibble_position;
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               fetch_valid;
		logic [TRACK_W-1:0] fetch_track;
		logic [NIB_W-1:0]   fetch_offset;
	} result_t;

endpackage

>>> hw/rtl/fssc_in_if.sv
`timescale 1ns / 1ps

interface fssc_in_if;
	logic                      valid;
	logic                      ready;
	logic [fssc_pkg::ADDR_W-1:0] bus_address;

	modport source (output valid, output bus_address, input ready);
	modport sink (input valid, input bus_address, output ready);
endinterface

>>> hw/rtl/fssc_out_if.sv
`timescale 1ns / 1ps

interface fssc_out_if;
	logic                         valid;
	logic                         ready;
	logic [fssc_pkg::DATA_W-1:0]  read_data;
	logic                         fetch_valid;
	logic [fssc_pkg::TRACK_W-1:0] fetch_track;
	logic [fssc_pkg::NIB_W-1:0]   fetch_offset;

	modport source (output valid, output read_data, output fetch_valid, output fetch_track,
		output fetch_offset, input ready);
	modport sink (input valid, input read_data, input fetch_valid, input fetch_track,
		input fetch_offset, output ready);
endinterface

>>> hw/rtl/floppy_stepper_switch_controller_core.sv
`timescale 1ns / 1ps

// Channel  Role    Payload                                                 Transaction
// bus      sink    bus_address[15:0]                                       valid & ready
// result   source  read_data[7:0] fetch_valid fetch_track[5:0]             valid & ready
//                  fetch_offset[12:0]
//
// Each access is registered, then decoded against the switch state combinationally, and
// its result is registered: an accepted access passes the input register, then the result register.
// Sustained rate is one access per cycle while results are taken; state update and result share one pass.
// arst_n clears all switch state, the head phase and the nibble position.
// A stalled result holds the input stage; a new access is still taken while the
// result register drains.

module floppy_stepper_switch_controller_core #(
	parameter int TRACK_NIBBLES  = fssc_pkg::TRACK_NIBBLES_DEF,
	parameter int MAX_HEAD_PHASE = fssc_pkg::MAX_HEAD_PHASE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fssc_in_if.sink           bus,
	fssc_out_if.source        result
);
	logic                        valid_s1;
	logic [fssc_pkg::ADDR_W-1:0] addr_s1;
	fssc_pkg::state_t            state_q;
	fssc_pkg::state_t            state_next;
	fssc_pkg::result_t           res_next;
	fssc_pkg::result_t           res_s2;
	logic                        valid_s2;
	logic                        advance;

	assign advance   = valid_s1 && (!valid_s2 || result.ready);
	assign bus.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bus.ready) begin
			valid_s1 <= bus.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bus.ready && bus.valid) begin
			addr_s1 <= bus.bus_address;
		end
	end

	fssc_step #(
		.TRACK_NIBBLES (TRACK_NIBBLES),
		.MAX_HEAD_PHASE(MAX_HEAD_PHASE)
	) u_step (
		.state      (state_q),
		.bus_address(addr_s1),
		.state_next (state_next),
		.result     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q  <= state_next;
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid        = valid_s2;
	assign result.read_data    = res_s2.read_data;
	assign result.fetch_valid  = res_s2.fetch_valid;
	assign result.fetch_track  = res_s2.fetch_track;
	assign result.fetch_offset = res_s2.fetch_offset;

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.head_phase <= fssc_pkg::PHASE_W'(MAX_HEAD_PHASE))
		else $error("head phase beyond its limit");

	a_position_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, state_q.nibble_position} < (fssc_pkg::NIB_W + 1)'(TRACK_NIBBLES))
		else $error("nibble position beyond track length");

	a_state_moves_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(state_q) |-> $past(advance))
		else $error("switch state changed without a processed transaction");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!bus.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input stalled while the pipeline could move");

	a_fetch_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.fetch_valid) |->
		(res_s2.fetch_track == '0 && res_s2.fetch_offset == '0))
		else $error("fetch fields set without a fetch");
endmodule

>>> hw/rtl/fssc_head.sv
`timescale 1ns / 1ps

module fssc_head #(
	parameter int MAX_HEAD_PHASE = fssc_pkg::MAX_HEAD_PHASE_DEF
) (
	input  logic [3:0]                   magnet_on,
	input  logic [fssc_pkg::PHASE_W-1:0] head_phase,
	output logic [fssc_pkg::PHASE_W-1:0] head_phase_next
);
	localparam logic [fssc_pkg::PHASE_W-1:0] PHASE_MAX = fssc_pkg::PHASE_W'(MAX_HEAD_PHASE);

	logic [1:0] cur_idx;
	logic       cur_on;
	logic       lower_on;
	logic       upper_on;

	always_comb begin
		cur_idx  = head_phase[1:0];
		cur_on   = magnet_on[cur_idx];
		lower_on = magnet_on[cur_idx - 2'd1];
		upper_on = magnet_on[cur_idx + 2'd1];
		head_phase_next = head_phase;
		// An energized magnet under the head holds it; two opposing pulls cancel.
		if (!cur_on) begin
			if (upper_on && !lower_on && head_phase < PHASE_MAX) begin
				head_phase_next = head_phase + 1'b1;
			end else if (lower_on && !upper_on && head_phase != '0) begin
				head_phase_next = head_phase - 1'b1;
			end
		end
	end
endmodule

>>> hw/rtl/fssc_step.sv
`timescale 1ns / 1ps

module fssc_step #(
	parameter int TRACK_NIBBLES  = fssc_pkg::TRACK_NIBBLES_DEF,
	parameter int MAX_HEAD_PHASE = fssc_pkg::MAX_HEAD_PHASE_DEF
) (
	input  fssc_pkg::state_t              state,
	input  logic [fssc_pkg::ADDR_W-1:0]   bus_address,
	output fssc_pkg::state_t              state_next,
	output fssc_pkg::result_t             result
);
	localparam logic [fssc_pkg::NIB_W:0] TRACK_END = (fssc_pkg::NIB_W + 1)'(TRACK_NIBBLES);

	localparam logic [3:0] SW_MAG_FIRST_C  = fssc_pkg::SW_MAG_FIRST;
	localparam logic [3:0] SW_MAG_LAST_C   = fssc_pkg::SW_MAG_LAST;
	localparam logic [3:0] SW_DRV_OFF_C    = fssc_pkg::SW_DRV_OFF;
	localparam logic [3:0] SW_DRV_ON_C     = fssc_pkg::SW_DRV_ON;
	localparam logic [3:0] SW_SEL_DRV0_C   = fssc_pkg::SW_SEL_DRV0;
	localparam logic [3:0] SW_SEL_DRV1_C   = fssc_pkg::SW_SEL_DRV1;
	localparam logic [3:0] SW_DATA_C       = fssc_pkg::SW_DATA;
	localparam logic [3:0] SW_NOP_C        = fssc_pkg::SW_NOP;
	localparam logic [3:0] SW_READ_MODE_C  = fssc_pkg::SW_READ_MODE;
	localparam logic [3:0] SW_WRITE_MODE_C = fssc_pkg::SW_WRITE_MODE;

	logic [3:0]                   sel;
	logic [3:0]                   magnets_new;
	logic [fssc_pkg::PHASE_W-1:0] phase_moved;
	logic [fssc_pkg::NIB_W:0]     pos_inc;

	assign sel = bus_address[3:0];

	always_comb begin
		magnets_new = state.magnet_on;
		magnets_new[sel[2:1]] = sel[0];
	end

	fssc_head #(
		.MAX_HEAD_PHASE(MAX_HEAD_PHASE)
	) u_head (
		.magnet_on      (magnets_new),
		.head_phase     (state.head_phase),
		.head_phase_next(phase_moved)
	);

	assign pos_inc = {1'b0, state.nibble_position} + 1'b1;

	always_comb begin
		state_next = state;
		result     = '0;
		unique case (sel) inside
			[SW_MAG_FIRST_C:SW_MAG_LAST_C]: begin
				state_next.magnet_on  = magnets_new;
				state_next.head_phase = phase_moved;
				if (bus_address == fssc_pkg::PHASE_PROBE_ADDR) begin
					result.read_data = fssc_pkg::PROBE_DATA;
				end
			end
			SW_DRV_OFF_C, SW_DRV_ON_C: begin
				state_next.drive_enabled[state.selected_drive] = sel[0];
			end
			SW_SEL_DRV0_C, SW_SEL_DRV1_C: begin
				state_next.selected_drive = sel[0];
			end
			SW_DATA_C: begin
				// Only drive 0 in read mode streams nibbles from the track memory.
				if (!state.selected_drive && !state.write_selected) begin
					result.fetch_valid  = 1'b1;
					result.fetch_track  = state.head_phase[fssc_pkg::PHASE_W-1:1];
					result.fetch_offset = state.nibble_position;
					if (pos_inc >= TRACK_END) begin
						state_next.nibble_position = '0;
					end else begin
						state_next.nibble_position = pos_inc[fssc_pkg::NIB_W-1:0];
					end
				end
			end
			SW_READ_MODE_C: begin
				state_next.write_selected = 1'b0;
			end
			SW_WRITE_MODE_C: begin
				state_next.write_selected = 1'b1;
			end
			SW_NOP_C: begin
				state_next = state;
			end
			default: begin
				state_next = state;
			end
		endcase
	end
endmodule

>>> tb/sv/floppy_stepper_switch_controller_core_test.sv
`timescale 1ns / 1ps

module floppy_stepper_switch_controller_core_test;

	localparam int TRACK_LEN = fssc_pkg::TRACK_NIBBLES_DEF;
	localparam int PHASE_MAX = fssc_pkg::MAX_HEAD_PHASE_DEF;
	localparam int PHASE_ITEMS = 220;
	localparam int HOLD_CYCLES = 300;
	localparam int EDGE_READS = 40;

	typedef struct {
		logic [fssc_pkg::ADDR_W-1:0] addr;
		bit                          typed;
		fssc_pkg::result_t           want;
	} access_row_t;

	logic clk;
	logic arst_n;

	fssc_in_if  bus_if ();
	fssc_out_if res_if ();

	floppy_stepper_switch_controller_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bus    (bus_if),
		.result (res_if)
	);

	// Model of the switch state, updated when each access is accepted.
	logic [3:0]                   mag_on;
	logic [fssc_pkg::PHASE_W-1:0] head_ph;
	logic                         drive_sel;
	logic [1:0]                   drive_en;
	logic                         write_mode;
	logic [fssc_pkg::NIB_W-1:0]   nib_pos;

	fssc_pkg::result_t expected_results[$];
	int                mismatch_count;
	int                accesses_sent;
	int                fetches_seen;
	int                peak_phase;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                hold_left;
	access_row_t       directed_rows[25];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#3_000_000;
		$display("Timeout with %0d results outstanding.", expected_results.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic fssc_pkg::result_t step_switches(logic [fssc_pkg::ADDR_W-1:0] a);
		fssc_pkg::result_t r;
		logic [3:0]        sel;
		logic [1:0]        cur, lower, upper;
		int                step, next;
		r = '0;
		sel = a[3:0];
		if (sel <= fssc_pkg::SW_MAG_LAST) begin
			mag_on[sel[2:1]] = sel[0];
			cur = head_ph[1:0];
			lower = cur - 2'd1;
			upper = cur + 2'd1;
			step = 0;
			if (!mag_on[cur]) begin
				if (mag_on[lower])
					step = step - 1;
				if (mag_on[upper])
					step = step + 1;
			end
			next = int'(head_ph) + step;
			if (next < 0)
				next = 0;
			if (next > PHASE_MAX)
				next = PHASE_MAX;
			head_ph = fssc_pkg::PHASE_W'(next);
			if (next > peak_phase)
				peak_phase = next;
			r.read_data = (a == fssc_pkg::PHASE_PROBE_ADDR) ? fssc_pkg::PROBE_DATA : '0;
		end else begin
			case (sel)
				fssc_pkg::SW_DRV_OFF, fssc_pkg::SW_DRV_ON: begin
					drive_en[drive_sel] = (sel == fssc_pkg::SW_DRV_ON);
				end
				fssc_pkg::SW_SEL_DRV0, fssc_pkg::SW_SEL_DRV1: begin
					drive_sel = (sel == fssc_pkg::SW_SEL_DRV1);
				end
				fssc_pkg::SW_DATA: begin
					if (!drive_sel && !write_mode) begin
						r.fetch_valid = 1'b1;
						r.fetch_track = head_ph[fssc_pkg::PHASE_W-1:1];
						r.fetch_offset = nib_pos;
						nib_pos = (int'(nib_pos) + 1 >= TRACK_LEN) ? '0 : nib_pos + 1'b1;
						fetches_seen++;
					end
				end
				fssc_pkg::SW_READ_MODE: begin
					write_mode = 1'b0;
				end
				fssc_pkg::SW_WRITE_MODE: begin
					write_mode = 1'b1;
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// Offers one access and waits for the transaction; typed_want replaces the prediction.
	task automatic send_access(input logic [fssc_pkg::ADDR_W-1:0] a, input bit typed = 1'b0,
			input fssc_pkg::result_t typed_want = '0);
		fssc_pkg::result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			bus_if.valid <= 1'b0;
			@(posedge clk);
		end
		bus_if.valid <= 1'b1;
		bus_if.bus_address <= a;
		do
			@(posedge clk);
		while (!bus_if.ready);
		predicted = step_switches(a);
		expected_results.push_back(typed ? typed_want : predicted);
		accesses_sent++;
	endtask

	task automatic drain_results();
		bus_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [11:0] pick_high_bits();
		case ($urandom_range(0, 3))
			0: return 12'h000;
			1: return 12'h00E;
			2: return 12'hFFF;
			default: return 12'($urandom());
		endcase
	endfunction

	task automatic release_magnets();
		for (int m = 0; m < 4; m++)
			send_access({pick_high_bits(), 4'(2 * m)});
	endtask

	// With all magnets off, energizing a neighbor pulls the head one phase toward it.
	task automatic seek_head(input bit outward, input int steps);
		logic [1:0] m;
		for (int i = 0; i < steps; i++) begin
			m = outward ? head_ph[1:0] + 2'd1 : head_ph[1:0] - 2'd1;
			send_access({pick_high_bits(), 4'({m, 1'b1})});
			send_access({pick_high_bits(), 4'({m, 1'b0})});
		end
	endtask

	task automatic run_random_phase(input int n_items);
		int start, kind, len;
		start = accesses_sent;
		while (accesses_sent - start < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				release_magnets();
				seek_head($urandom_range(0, 1), $urandom_range(1, 40));
			end else if (kind < 68) begin
				if ($urandom_range(0, 3) == 0)
					send_access({pick_high_bits(), fssc_pkg::SW_SEL_DRV0});
				if ($urandom_range(0, 3) == 0)
					send_access({pick_high_bits(), fssc_pkg::SW_READ_MODE});
				len = $urandom_range(1, 20);
				repeat (len)
					send_access({pick_high_bits(), fssc_pkg::SW_DATA});
			end else if (kind < 83) begin
				send_access({pick_high_bits(),
					4'($urandom_range(fssc_pkg::SW_DRV_OFF, fssc_pkg::SW_WRITE_MODE))});
			end else if (kind < 97) begin
				send_access(fssc_pkg::ADDR_W'($urandom()));
			end else begin
				drain_results();
			end
		end
	endtask

	// Result side: checks each transaction, then picks ready for the next cycle.
	initial begin
		fssc_pkg::result_t got, want;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				got.read_data = res_if.read_data;
				got.fetch_valid = res_if.fetch_valid;
				got.fetch_track = res_if.fetch_track;
				got.fetch_offset = res_if.fetch_offset;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", got));
				end else begin
					want = expected_results.pop_front();
					if (got.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %h, want %h",
							got.read_data, want.read_data));
					if (got.fetch_valid !== want.fetch_valid)
						report_mismatch($sformatf("fetch_valid %b, want %b",
							got.fetch_valid, want.fetch_valid));
					if (got.fetch_track !== want.fetch_track)
						report_mismatch($sformatf("fetch_track %0d, want %0d",
							got.fetch_track, want.fetch_track));
					if (got.fetch_offset !== want.fetch_offset)
						report_mismatch($sformatf("fetch_offset %0d, want %0d",
							got.fetch_offset, want.fetch_offset));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		bus_if.valid <= 1'b0;
		bus_if.bus_address <= '0;
		mag_on = '0;
		head_ph = '0;
		drive_sel = 1'b0;
		drive_en = '0;
		write_mode = 1'b0;
		nib_pos = '0;
		mismatch_count = 0;
		accesses_sent = 0;
		fetches_seen = 0;
		peak_phase = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;

		directed_rows = '{
			'{16'h00E0, 1'b1, {8'hFF, 1'b0, 6'd0, 13'd0}},
			'{16'h000C, 1'b1, {8'h00, 1'b1, 6'd0, 13'd0}},
			'{16'h0007, 1'b0, '0},
			'{16'h100C, 1'b1, {8'h00, 1'b1, 6'd0, 13'd1}},
			'{16'h0006, 1'b0, '0},
			'{16'h0003, 1'b0, '0},
			'{16'h0001, 1'b0, '0},
			'{16'h0005, 1'b0, '0},
			'{16'h0002, 1'b0, '0},
			'{16'hFFEC, 1'b0, '0},
			'{16'h0000, 1'b0, '0},
			'{16'h000C, 1'b0, '0},
			'{16'h000F, 1'b0, '0},
			'{16'h000C, 1'b1, '0},
			'{16'h000E, 1'b0, '0},
			'{16'h000B, 1'b0, '0},
			'{16'h000C, 1'b1, '0},
			'{16'h0009, 1'b0, '0},
			'{16'h0008, 1'b0, '0},
			'{16'h000A, 1'b0, '0},
			'{16'h000D, 1'b1, '0},
			'{16'hFFE0, 1'b1, '0},
			'{16'h00E1, 1'b0, '0},
			'{16'hFFFE, 1'b0, '0},
			'{16'h000C, 1'b0, '0}
		};

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed accesses: probe address, clamp at phase zero, cancelling neighbors,
		// data reads blocked by write mode and by drive 1.
		foreach (directed_rows[i])
			send_access(directed_rows[i].addr, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			run_random_phase(PHASE_ITEMS);
			drain_results();
		end

		// The receiver holds off while accesses keep coming, so the input side backs up.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		run_random_phase(60);
		drain_results();

		// Full head travel with clamping at the top, data reads on the outermost track,
		// then back down to phase zero.
		send_access({12'h000, fssc_pkg::SW_SEL_DRV0});
		send_access({12'h000, fssc_pkg::SW_READ_MODE});
		release_magnets();
		seek_head(1'b1, PHASE_MAX + 2);
		repeat (EDGE_READS)
			send_access({pick_high_bits(), fssc_pkg::SW_DATA});
		release_magnets();
		seek_head(1'b0, PHASE_MAX + 2);
		send_access({12'h000, fssc_pkg::SW_DATA});
		drain_results();
		repeat (20)
			@(posedge clk);

		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("Ran %0d bus accesses under four idling patterns and a long result stall.",
			accesses_sent);
		$display("Predicted %0d nibble fetches; head phase reached %0d; mismatches: %0d.",
			fetches_seen, peak_phase, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
